// ----- rtl/core/lps_pkg.sv -----
package lps_pkg;

  // Fixed field widths of the ports
  localparam int FIELD_BITS     = 6;
  localparam int CLIP_BITS      = 7;
  localparam int COORD_BITS_DEF = 6;

  // Configuration port
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  // Register select, taken from paddr[2]
  localparam logic REG_CLIP_WIDTH  = 1'b0;
  localparam logic REG_CLIP_HEIGHT = 1'b1;

  // Step direction of one axis
  localparam logic [1:0] DIR_HOLD = 2'd0;
  localparam logic [1:0] DIR_INC  = 2'd1;
  localparam logic [1:0] DIR_DEC  = 2'd2;

  typedef struct packed {
    logic [FIELD_BITS-1:0] start_x;
    logic [FIELD_BITS-1:0] start_y;
    logic [FIELD_BITS-1:0] end_x;
    logic [FIELD_BITS-1:0] end_y;
    logic                  ink;
  } line_cmd_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] pixel_x;
    logic [FIELD_BITS-1:0] pixel_y;
    logic                  pixel_value;
    logic                  visible;
    logic                  last;
  } pixel_wr_t;

  typedef struct packed {
    logic [CLIP_BITS-1:0] clip_width;
    logic [CLIP_BITS-1:0] clip_height;
  } clip_cfg_t;

endpackage

// ----- rtl/core/lps_cfg.sv -----
module lps_cfg
  import lps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output clip_cfg_t            clip
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip.clip_width  <= '0;
      clip.clip_height <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_CLIP_WIDTH:  clip.clip_width  <= pwdata[CLIP_BITS-1:0];
        REG_CLIP_HEIGHT: clip.clip_height <= pwdata[CLIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CLIP_WIDTH:  prdata = DATA_BITS'(clip.clip_width);
      REG_CLIP_HEIGHT: prdata = DATA_BITS'(clip.clip_height);
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/lps_axis_unit.sv -----
// One error-accumulator step: add delta, and on reaching span wrap the
// error and move the coordinate one place.
module lps_axis_unit
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic [COORD_BITS:0]   err,
  input  logic [COORD_BITS-1:0] delta,
  input  logic [COORD_BITS-1:0] span,
  input  logic [COORD_BITS-1:0] coord,
  input  logic [1:0]            dir,
  output logic [COORD_BITS:0]   err_next,
  output logic [COORD_BITS-1:0] coord_next
);

  logic [COORD_BITS:0] sum;
  logic [COORD_BITS:0] span_ext;
  logic                reach;

  assign span_ext = (COORD_BITS+1)'(span);
  assign sum      = err + (COORD_BITS+1)'(delta);
  assign reach    = (sum >= span_ext);
  assign err_next = reach ? (sum - span_ext) : sum;

  always_comb begin
    coord_next = coord;
    if (reach) begin
      case (dir)
        DIR_INC: coord_next = coord + COORD_BITS'(1);
        DIR_DEC: coord_next = coord - COORD_BITS'(1);
        default: coord_next = coord;
      endcase
    end
  end

endmodule

// ----- rtl/core/lps_stepper.sv -----
module lps_stepper
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  line_cmd_t in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output pixel_wr_t out_data,
  input  clip_cfg_t clip
);

  localparam int ERR_BITS = COORD_BITS + 1;
  localparam int CNT_BITS = COORD_BITS + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_XSTEP = 2'd1;
  localparam logic [1:0] ST_YSTEP = 2'd2;

  logic [1:0]            state;
  logic [COORD_BITS-1:0] cur_x, cur_y;
  logic [ERR_BITS-1:0]   err_x, err_y;
  logic [COORD_BITS-1:0] dx, dy, span;
  logic [1:0]            dir_x, dir_y;
  logic                  ink;
  logic [CNT_BITS-1:0]   steps_left;

  // command decode
  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [COORD_BITS-1:0] cmd_dx, cmd_dy, cmd_dist;
  logic [1:0]            cmd_dir_x, cmd_dir_y;

  // shared axis unit
  logic                  use_y;
  logic [ERR_BITS-1:0]   u_err, u_err_next;
  logic [COORD_BITS-1:0] u_delta, u_coord, u_coord_next;
  logic [1:0]            u_dir;

  logic accept, slot_free, emit, vis;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign emit      = (state == ST_XSTEP) && slot_free;

  assign sx = in_data.start_x[COORD_BITS-1:0];
  assign sy = in_data.start_y[COORD_BITS-1:0];
  assign ex = in_data.end_x[COORD_BITS-1:0];
  assign ey = in_data.end_y[COORD_BITS-1:0];

  always_comb begin
    if (ex > sx) begin
      cmd_dx = ex - sx;  cmd_dir_x = DIR_INC;
    end else if (ex < sx) begin
      cmd_dx = sx - ex;  cmd_dir_x = DIR_DEC;
    end else begin
      cmd_dx = '0;       cmd_dir_x = DIR_HOLD;
    end
    if (ey > sy) begin
      cmd_dy = ey - sy;  cmd_dir_y = DIR_INC;
    end else if (ey < sy) begin
      cmd_dy = sy - ey;  cmd_dir_y = DIR_DEC;
    end else begin
      cmd_dy = '0;       cmd_dir_y = DIR_HOLD;
    end
    cmd_dist = (cmd_dx > cmd_dy) ? cmd_dx : cmd_dy;
  end

  assign use_y   = (state == ST_YSTEP);
  assign u_err   = use_y ? err_y : err_x;
  assign u_delta = use_y ? dy    : dx;
  assign u_coord = use_y ? cur_y : cur_x;
  assign u_dir   = use_y ? dir_y : dir_x;

  lps_axis_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_axis (
    .err        (u_err),
    .delta      (u_delta),
    .span       (span),
    .coord      (u_coord),
    .dir        (u_dir),
    .err_next   (u_err_next),
    .coord_next (u_coord_next)
  );

  assign vis = (CLIP_BITS'(cur_x) < clip.clip_width) &&
               (CLIP_BITS'(cur_y) < clip.clip_height);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE:  if (accept) state <= ST_XSTEP;
        ST_XSTEP: if (emit) state <= ST_YSTEP;
        ST_YSTEP: state <= (steps_left == '0) ? ST_IDLE : ST_XSTEP;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x      <= sx;
      cur_y      <= sy;
      err_x      <= '0;
      err_y      <= '0;
      dx         <= cmd_dx;
      dy         <= cmd_dy;
      span       <= cmd_dist;
      dir_x      <= cmd_dir_x;
      dir_y      <= cmd_dir_y;
      ink        <= in_data.ink;
      steps_left <= CNT_BITS'(cmd_dist) + CNT_BITS'(1);
    end
    if (emit) begin
      out_data.pixel_x     <= FIELD_BITS'(cur_x);
      out_data.pixel_y     <= FIELD_BITS'(cur_y);
      out_data.pixel_value <= ink;
      out_data.visible     <= vis;
      out_data.last        <= (steps_left == CNT_BITS'(1));
      err_x                <= u_err_next;
      cur_x                <= u_coord_next;
      steps_left           <= steps_left - CNT_BITS'(1);
    end
    if (state == ST_YSTEP) begin
      err_y <= u_err_next;
      cur_y <= u_coord_next;
    end
  end

endmodule

// ----- rtl/core/line_pixel_stepper.sv -----
// Line pixel stepper: takes one line command (two endpoints and an ink bit)
// and sends out distance+1 pixel writes, distance being the larger of |dx|
// and |dy|, walking from the start point to the end point; the last write
// of a line has last set, and writes at x >= clip_width or y >= clip_height
// come out with visible cleared. Each pixel is walked in an x-step state
// and then a y-step state, because one shared add/compare/step unit
// serves the x accumulator and then the y accumulator. in_stall is high
// for the whole line. One finished pixel is held in the output register;
// while the consumer has not yet taken it, the walk waits in the x-step
// state.
module line_pixel_stepper
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration (APB-style; clip_width at 0x0, clip_height at 0x4)
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  // line command transfer
  input  logic                 in_valid,
  output logic                 in_stall,
  input  line_cmd_t            in_data,
  // pixel write transfer
  output logic                 out_valid,
  input  logic                 out_stall,
  output pixel_wr_t            out_data
);

  clip_cfg_t clip;

  // clip registers; the user writes them only while no line is in flight (not enforced here)
  lps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .clip    (clip)
  );

  // sequencer, accumulators and output register
  lps_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .clip      (clip)
  );

endmodule

// ----- bench/tb_line_pixel_stepper.sv -----
module tb_line_pixel_stepper;
  timeunit 1ns;
  timeprecision 1ps;
  import lps_pkg::*;

  localparam int CMD_BITS = $bits(line_cmd_t);

  // Clock and synchronous reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  // Configuration port; every input starts from a known value
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [ADDR_BITS-1:0] paddr   = '0;
  logic [DATA_BITS-1:0] pwdata  = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // Line command and pixel write channels
  logic      in_valid  = 1'b0;
  logic      in_stall;
  line_cmd_t in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pixel_wr_t out_data;

  line_pixel_stepper dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Bench copy of the clip registers, reset value zero
  logic [CLIP_BITS-1:0] clip_w = '0;
  logic [CLIP_BITS-1:0] clip_h = '0;

  // Pixel writes predicted but not yet seen on the output
  pixel_wr_t pending_pixels[$];

  // Random idling on both channels; cleared for one quiet phase
  bit idle_on = 1'b0;

  int fault_count  = 0;
  int lines_sent   = 0;
  int pixels_seen  = 0;
  int visible_seen = 0;
  int clip_writes  = 0;

  // One printed line per mismatch; printing is capped, counting is not
  task automatic note_bad(input string msg);
    fault_count++;
    if (fault_count <= 30)
      $display("ERROR %0t ns: %s", $time, msg);
  endtask

  // One coordinate step toward the endpoint, wrapping at 6 bits
  function automatic logic [FIELD_BITS-1:0] step_axis(input logic [FIELD_BITS-1:0] c,
                                                      input logic [1:0] dir);
    case (dir)
      DIR_INC: return c + FIELD_BITS'(1);
      DIR_DEC: return c - FIELD_BITS'(1);
      default: return c;
    endcase
  endfunction

  // DDA walk of one line under the current clip; queues every pixel write
  function automatic void trace_line(input line_cmd_t c);
    logic [FIELD_BITS-1:0] x, y;
    logic [CLIP_BITS-1:0]  ddx, ddy, span, acc_x, acc_y, left;
    logic [1:0]            dir_x, dir_y;
    pixel_wr_t             p;
    x = c.start_x;
    y = c.start_y;
    ddx = {1'b0, (c.end_x > c.start_x) ? c.end_x - c.start_x : c.start_x - c.end_x};
    ddy = {1'b0, (c.end_y > c.start_y) ? c.end_y - c.start_y : c.start_y - c.end_y};
    dir_x = (c.end_x > c.start_x) ? DIR_INC : (c.end_x < c.start_x) ? DIR_DEC : DIR_HOLD;
    dir_y = (c.end_y > c.start_y) ? DIR_INC : (c.end_y < c.start_y) ? DIR_DEC : DIR_HOLD;
    span  = (ddx > ddy) ? ddx : ddy;
    left  = span + CLIP_BITS'(1);
    acc_x = '0;
    acc_y = '0;
    while (left != 0) begin
      p.pixel_x     = x;
      p.pixel_y     = y;
      p.pixel_value = c.ink;
      p.visible     = ({1'b0, x} < clip_w) && ({1'b0, y} < clip_h);
      p.last        = (left == 1);
      pending_pixels.push_back(p);
      // accumulators never pass 126, so 7 bits hold them
      acc_x = acc_x + ddx;
      acc_y = acc_y + ddy;
      if (acc_x >= span) begin
        acc_x = acc_x - span;
        x = step_axis(x, dir_x);
      end
      if (acc_y >= span) begin
        acc_y = acc_y - span;
        y = step_axis(y, dir_y);
      end
      left = left - CLIP_BITS'(1);
    end
  endfunction

  // Command transfer: optional idle cycles, then hold valid until taken.
  // Valid stays high afterwards; the next send or settle_idle decides.
  task automatic send_line(input line_cmd_t c);
    while (idle_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall);
    lines_sent++;
  endtask

  // Drop valid and wait until every predicted pixel has come out
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then the bus is released
  task automatic write_clip(input logic sel, input logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_CLIP_WIDTH)
      clip_w = value[CLIP_BITS-1:0];
    else
      clip_h = value[CLIP_BITS-1:0];
    clip_writes++;
    @(posedge clk);
  endtask

  // Pixel side: values read here are the ones before the edge; out_stall
  // is redrawn each cycle while idling is on.
  always @(posedge clk) begin : check_pixels
    pixel_wr_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        pixels_seen++;
        if (out_data.visible === 1'b1)
          visible_seen++;
        if (pending_pixels.size() == 0) begin
          note_bad($sformatf("pixel (%0d,%0d) with no line pending",
                             out_data.pixel_x, out_data.pixel_y));
        end else begin
          want = pending_pixels.pop_front();
          if (out_data.pixel_x !== want.pixel_x)
            note_bad($sformatf("pixel_x got %0d want %0d", out_data.pixel_x, want.pixel_x));
          if (out_data.pixel_y !== want.pixel_y)
            note_bad($sformatf("pixel_y got %0d want %0d", out_data.pixel_y, want.pixel_y));
          if (out_data.pixel_value !== want.pixel_value)
            note_bad($sformatf("pixel_value got %b want %b at (%0d,%0d)",
                               out_data.pixel_value, want.pixel_value,
                               want.pixel_x, want.pixel_y));
          if (out_data.visible !== want.visible)
            note_bad($sformatf("visible got %b want %b at (%0d,%0d)",
                               out_data.visible, want.visible, want.pixel_x, want.pixel_y));
          if (out_data.last !== want.last)
            note_bad($sformatf("last got %b want %b at (%0d,%0d)",
                               out_data.last, want.last, want.pixel_x, want.pixel_y));
        end
      end
      out_stall <= idle_on && ($urandom_range(99) < 9);
    end
  end

  // Directed rows: clip raw values, the command, and for single-pixel lines
  // the visible bit typed in by hand
  typedef struct {
    logic [DATA_BITS-1:0] w_raw;
    logic [DATA_BITS-1:0] h_raw;
    line_cmd_t            cmd;
    bit                   typed;
    logic                 vis;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic dir_row_t line_row(input logic [DATA_BITS-1:0] w, h,
                                        input logic [FIELD_BITS-1:0] sx, sy, ex, ey,
                                        input logic ink);
    dir_row_t r;
    r.w_raw = w;
    r.h_raw = h;
    r.cmd   = '{start_x: sx, start_y: sy, end_x: ex, end_y: ey, ink: ink};
    r.typed = 1'b0;
    r.vis   = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t dot_row(input logic [DATA_BITS-1:0] w, h,
                                       input logic [FIELD_BITS-1:0] x, y,
                                       input logic ink, vis);
    dir_row_t r;
    r = line_row(w, h, x, y, x, y, ink);
    r.typed = 1'b1;
    r.vis   = vis;
    return r;
  endfunction

  initial begin : stimulus
    line_cmd_t                     cmd;
    pixel_wr_t                     dot;
    logic [CMD_BITS-1:0]           raw;
    logic [DATA_BITS-1:0]          w_pick[8];
    logic [DATA_BITS-1:0]          h_pick[8];
    int                            kind, d, a, b;

    // Reset clip (zero): nothing is visible
    dir_rows.push_back(dot_row(32'h0, 32'h0, 6'd5, 6'd9, 1'b1, 1'b0));
    dir_rows.push_back(line_row(32'h0, 32'h0, 6'd0, 6'd0, 6'd63, 6'd63, 1'b0));
    dir_rows.push_back(dot_row(32'h0, 32'h0, 6'd63, 6'd63, 1'b0, 1'b0));
    // Clip 64 written with junk above bit 6: whole grid visible
    dir_rows.push_back(dot_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd63, 6'd63, 1'b1, 1'b1));
    dir_rows.push_back(dot_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd0, 6'd0, 1'b0, 1'b1));
    dir_rows.push_back(line_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd0, 6'd0, 6'd63, 6'd63, 1'b1));
    dir_rows.push_back(line_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd63, 6'd63, 6'd0, 6'd0, 1'b0));
    dir_rows.push_back(line_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd0, 6'd63, 6'd63, 6'd0, 1'b1));
    dir_rows.push_back(line_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd63, 6'd0, 6'd0, 6'd63, 1'b0));
    dir_rows.push_back(line_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd0, 6'd0, 6'd63, 6'd0, 1'b1));
    dir_rows.push_back(line_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd63, 6'd5, 6'd0, 6'd5, 1'b0));
    dir_rows.push_back(line_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd7, 6'd0, 6'd7, 6'd63, 1'b1));
    dir_rows.push_back(line_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd7, 6'd63, 6'd7, 6'd0, 1'b0));
    dir_rows.push_back(line_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd10, 6'd0, 6'd12, 6'd63, 1'b1));
    dir_rows.push_back(line_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd0, 6'd20, 6'd63, 6'd22, 1'b0));
    dir_rows.push_back(line_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd3, 6'd4, 6'd4, 6'd5, 1'b1));
    dir_rows.push_back(line_row(32'hFFFF_FFC0, 32'hFFFF_FFC0, 6'd1, 6'd1, 6'd2, 6'd1, 1'b0));
    // Partial clip: line crosses both edges
    dir_rows.push_back(line_row(32'h20, 32'h10, 6'd0, 6'd0, 6'd63, 6'd63, 1'b1));
    dir_rows.push_back(line_row(32'h20, 32'h10, 6'd40, 6'd2, 6'd1, 6'd50, 1'b0));
    // Smallest nonzero clip: only the origin shows
    dir_rows.push_back(dot_row(32'h1, 32'h1, 6'd0, 6'd0, 1'b1, 1'b1));
    dir_rows.push_back(dot_row(32'h1, 32'h1, 6'd1, 6'd0, 1'b1, 1'b0));
    // Clip 63: the top coordinate is just outside
    dir_rows.push_back(dot_row(32'h3F, 32'h3F, 6'd62, 6'd62, 1'b0, 1'b1));
    dir_rows.push_back(dot_row(32'h3F, 32'h3F, 6'd63, 6'd62, 1'b1, 1'b0));
    dir_rows.push_back(line_row(32'h3F, 32'h3F, 6'd63, 6'd63, 6'd60, 6'd0, 1'b1));
    // Zero width alone hides everything
    dir_rows.push_back(dot_row(32'h0, 32'h40, 6'd0, 6'd0, 1'b1, 1'b0));

    // Clip settings of the random phases; zero entries in 5 and 6 get drawn
    w_pick = '{32'hFFFF_FFFF, 32'h0, 32'h1, 32'h3F, 32'hFFFF_FFC0, 32'h0, 32'h0, 32'h20};
    h_pick = '{32'hFFFF_FFFF, 32'h40, 32'h1, 32'h3F, 32'h41, 32'h0, 32'h0, 32'h80};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on = 1'b1;

    // Directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].w_raw[CLIP_BITS-1:0] != clip_w ||
          dir_rows[i].h_raw[CLIP_BITS-1:0] != clip_h) begin
        settle_idle();
        write_clip(REG_CLIP_WIDTH, dir_rows[i].w_raw);
        write_clip(REG_CLIP_HEIGHT, dir_rows[i].h_raw);
      end
      send_line(dir_rows[i].cmd);
      if (dir_rows[i].typed) begin
        dot.pixel_x     = dir_rows[i].cmd.start_x;
        dot.pixel_y     = dir_rows[i].cmd.start_y;
        dot.pixel_value = dir_rows[i].cmd.ink;
        dot.visible     = dir_rows[i].vis;
        dot.last        = 1'b1;
        pending_pixels.push_back(dot);
      end else begin
        trace_line(dir_rows[i].cmd);
      end
    end

    // Random part: eight clip settings, phase 3 runs with no idling at all
    for (int ph = 0; ph < 8; ph++) begin
      settle_idle();
      idle_on = (ph != 3);
      write_clip(REG_CLIP_WIDTH, (ph == 5 || ph == 6) ? $urandom : w_pick[ph]);
      write_clip(REG_CLIP_HEIGHT, (ph == 5 || ph == 6) ? $urandom : h_pick[ph]);
      for (int n = 0; n < 38; n++) begin
        kind = $urandom_range(9);
        cmd.start_x = FIELD_BITS'($urandom_range(63));
        cmd.start_y = FIELD_BITS'($urandom_range(63));
        cmd.ink     = 1'($urandom_range(1));
        case (kind)
          0: begin
            // single pixel
            cmd.end_x = cmd.start_x;
            cmd.end_y = cmd.start_y;
          end
          1: begin
            cmd.end_x = FIELD_BITS'($urandom_range(63));
            cmd.end_y = cmd.start_y;
          end
          2: begin
            cmd.end_x = cmd.start_x;
            cmd.end_y = FIELD_BITS'($urandom_range(63));
          end
          3: begin
            // 45-degree line, any of the four directions
            d = $urandom_range(63);
            a = $urandom_range(63 - d);
            b = $urandom_range(63 - d);
            if ($urandom_range(1)) begin
              cmd.start_x = FIELD_BITS'(a);
              cmd.end_x   = FIELD_BITS'(a + d);
            end else begin
              cmd.start_x = FIELD_BITS'(a + d);
              cmd.end_x   = FIELD_BITS'(a);
            end
            if ($urandom_range(1)) begin
              cmd.start_y = FIELD_BITS'(b);
              cmd.end_y   = FIELD_BITS'(b + d);
            end else begin
              cmd.start_y = FIELD_BITS'(b + d);
              cmd.end_y   = FIELD_BITS'(b);
            end
          end
          4, 5: begin
            // short line; wraps near the edges into a long one
            cmd.end_x = cmd.start_x + 6'($urandom_range(6)) - 6'd3;
            cmd.end_y = cmd.start_y + 6'($urandom_range(6)) - 6'd3;
          end
          default: begin
            raw = CMD_BITS'($urandom);
            cmd = raw;
          end
        endcase
        send_line(cmd);
        trace_line(cmd);
        // now and then hold off until the stepper has drained
        if ($urandom_range(29) == 0)
          settle_idle();
      end
    end

    settle_idle();
    repeat (40) @(posedge clk);

    $display("Covered %0d lines under %0d clip register writes: %0d pixel writes,",
             lines_sent, clip_writes, pixels_seen);
    $display("%0d of them inside the clip window, %0d mismatches.",
             visible_seen, fault_count);
    if (fault_count == 0 && pending_pixels.size() == 0)
      $display("line_pixel_stepper test passed");
    else
      $display("line_pixel_stepper test failed");
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("Timeout with %0d pixel writes outstanding", pending_pixels.size());
    $display("line_pixel_stepper test failed");
    $finish;
  end

endmodule

// ----- line_pixel_stepper.f -----
rtl/core/lps_pkg.sv
rtl/core/lps_cfg.sv
rtl/core/lps_axis_unit.sv
rtl/core/lps_stepper.sv
rtl/core/line_pixel_stepper.sv
bench/tb_line_pixel_stepper.sv
